FILE: rtl/csf_pkg.sv
// csf_pkg: shared types and constants for the character stuffing framer.
// Holds the word structs, the command passed from front to back and the slot map.
// No dependencies.
`default_nettype none
package csf_pkg;

    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_E = 8'h65;

    localparam int QUEUE_DEPTH = 2;

    // Output slots, in emission order.
    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = 4;
    localparam logic [SLOT_W-1:0] SLOT_STX_S = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_STX_T = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_STX_X = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_TOK_0 = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_TOK_1 = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_TOK_2 = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_HEAD  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_FL_0  = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_FL_1  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_ETX_E = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_ETX_T = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_ETX_X = 4'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
    } t_out_word;

    // mask: one bit per slot to emit; byte_a..c: window bytes, or flush bytes
    // in byte_a/byte_b when no window completed.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           byte_a;
        logic [7:0]           byte_b;
        logic [7:0]           byte_c;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/csf_front.sv
// csf_front: accepts input words, tracks the lookahead bytes and frame state,
// and classifies each word into a command for the back end. Uses csf_pkg.
`default_nettype none
module csf_front
    import csf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic [7:0] r_lk0, r_lk1, n_lk0, n_lk1;
    logic [1:0] r_cnt, n_cnt;
    logic       r_in_frame, n_in_frame;

    logic       acc;
    logic       win;
    logic       tok;
    logic [1:0] cnt_cur;
    logic [1:0] held;

    function automatic logic is_token(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
        return (a == CH_D && b == CH_L && c == CH_E) ||
               (a == CH_S && b == CH_T && c == CH_X) ||
               (a == CH_E && b == CH_T && c == CH_X);
    endfunction

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;

    always_comb begin
        n_lk0      = r_lk0;
        n_lk1      = r_lk1;
        n_cnt      = r_cnt;
        n_in_frame = r_in_frame;
        o_cmd      = '0;
        win        = 1'b0;
        held       = 2'd0;
        cnt_cur    = r_in_frame ? r_cnt : 2'd0;

        case (cnt_cur)
            2'd0: begin
                o_cmd.byte_a = i_data.data_byte;
                n_lk0        = i_data.data_byte;
                held         = 2'd1;
            end
            2'd1: begin
                o_cmd.byte_a = r_lk0;
                o_cmd.byte_b = i_data.data_byte;
                n_lk1        = i_data.data_byte;
                held         = 2'd2;
            end
            default: begin
                o_cmd.byte_a = r_lk0;
                o_cmd.byte_b = r_lk1;
                o_cmd.byte_c = i_data.data_byte;
                n_lk0        = r_lk1;
                n_lk1        = i_data.data_byte;
                win          = 1'b1;
                held         = 2'd2;
            end
        endcase
        tok = win && is_token(o_cmd.byte_a, o_cmd.byte_b, o_cmd.byte_c);

        o_cmd.mask[SLOT_STX_S] = !r_in_frame;
        o_cmd.mask[SLOT_STX_T] = !r_in_frame;
        o_cmd.mask[SLOT_STX_X] = !r_in_frame;
        o_cmd.mask[SLOT_TOK_0] = tok;
        o_cmd.mask[SLOT_TOK_1] = tok;
        o_cmd.mask[SLOT_TOK_2] = tok;
        o_cmd.mask[SLOT_HEAD]  = win;
        o_cmd.mask[SLOT_FL_0]  = i_data.frame_end;
        o_cmd.mask[SLOT_FL_1]  = i_data.frame_end && (held == 2'd2);
        o_cmd.mask[SLOT_ETX_E] = i_data.frame_end;
        o_cmd.mask[SLOT_ETX_T] = i_data.frame_end;
        o_cmd.mask[SLOT_ETX_X] = i_data.frame_end;

        if (i_data.frame_end) begin
            n_cnt      = 2'd0;
            n_in_frame = 1'b0;
        end else begin
            n_cnt      = held;
            n_in_frame = 1'b1;
        end

        o_push = acc && (o_cmd.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 2'd0;
            r_in_frame <= 1'b0;
        end else if (acc) begin
            r_cnt      <= n_cnt;
            r_in_frame <= n_in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lk0 <= n_lk0;
            r_lk1 <= n_lk1;
        end
    end

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_data.frame_end |=> !r_in_frame && r_cnt == 2'd0)
        else $error("frame end did not close the frame");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("held byte count out of range");

endmodule
`default_nettype wire

FILE: rtl/csf_queue.sv
// csf_queue: short command queue between front and back end.
// Register-based FIFO of t_cmd entries. Uses csf_pkg.
`default_nettype none
module csf_queue
    import csf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push)
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        if (do_pop)
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        if (do_push && !do_pop)
            n_count = r_count + 1'b1;
        else if (do_pop && !do_push)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wptr] <= i_cmd;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/csf_back.sv
// csf_back: expands queued commands into output words, one slot per cycle while
// the output register can take a word, into a registered output stage. Uses csf_pkg.
`default_nettype none
module csf_back
    import csf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_q_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_word o_data
);

    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    logic [7:0]           r_a, r_b, r_c;
    logic                 r_win;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_odata, n_odata;

    logic                 have, out_free, emit, load;
    logic [SLOT_W-1:0]    slot;
    logic [NUM_SLOTS-1:0] rest;
    logic [7:0]           slot_byte;

    function automatic logic [SLOT_W-1:0] first_slot(input logic [NUM_SLOTS-1:0] m);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (m[k])
                idx = SLOT_W'(k);
        end
        return idx;
    endfunction

    always_comb begin
        have     = (r_mask != '0);
        out_free = !r_ovalid || i_ready;
        slot     = first_slot(r_mask);
        rest     = r_mask & ~(NUM_SLOTS'(1) << slot);
        emit     = have && out_free;
        load     = i_q_valid && (!have || (emit && rest == '0));

        unique case (slot)
            SLOT_STX_S: slot_byte = CH_S;
            SLOT_STX_T: slot_byte = CH_T;
            SLOT_STX_X: slot_byte = CH_X;
            SLOT_TOK_0: slot_byte = r_a;
            SLOT_TOK_1: slot_byte = r_b;
            SLOT_TOK_2: slot_byte = r_c;
            SLOT_HEAD:  slot_byte = r_a;
            SLOT_FL_0:  slot_byte = r_win ? r_b : r_a;
            SLOT_FL_1:  slot_byte = r_win ? r_c : r_b;
            SLOT_ETX_E: slot_byte = CH_E;
            SLOT_ETX_T: slot_byte = CH_T;
            SLOT_ETX_X: slot_byte = CH_X;
            default:    slot_byte = CH_X;
        endcase

        n_mask = r_mask;
        if (load)
            n_mask = i_q_cmd.mask;
        else if (emit)
            n_mask = rest;

        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (emit) begin
            n_ovalid           = 1'b1;
            n_odata.out_byte   = slot_byte;
            n_odata.run_last   = (rest == '0);
            n_odata.frame_done = (slot == SLOT_ETX_X);
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_q_pop = load;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_mask   <= n_mask;
            r_ovalid <= n_ovalid;
        end
    end

    // r_win: the command completed a window, so flush bytes sit in b/c
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        if (load) begin
            r_a   <= i_q_cmd.byte_a;
            r_b   <= i_q_cmd.byte_b;
            r_c   <= i_q_cmd.byte_c;
            r_win <= i_q_cmd.mask[SLOT_HEAD];
        end
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_done |-> o_data.run_last)
        else $error("frame_done without run_last");

    a_load_empty_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> i_q_cmd.mask != '0)
        else $error("empty command loaded");

endmodule
`default_nettype wire

FILE: rtl/char_stuffing_framer_top.sv
// char_stuffing_framer_top: DLE/STX/ETX character stuffing framer.
// Instantiates csf_front, csf_queue and csf_back. Uses csf_pkg.
//
// Input channel (i_valid/o_ready/i_data): one payload byte per word, with
// frame_end set on the last byte of a frame. Output channel
// (o_valid/i_ready/o_data): one framed byte per word; run_last marks the last
// output word caused by an input word, frame_done marks the closing 'x'.
// The first word of a frame is preceded by "stx"; bytes are held two deep so
// that "dle", "stx" and "etx" sequences can be doubled; frame_end flushes the
// held bytes and appends "etx". An input word that starts no frame, completes
// no window and ends no frame produces nothing.
// Each input's output words pass through the command queue, the back end's
// slot mask and the output register before they appear on o_valid. The back
// end emits one output word per cycle while the output side accepts; the
// two-entry command queue lets input continue while the back end expands an
// earlier word. When i_ready is low the output register holds its word, the
// back end stops, the queue fills, and o_ready drops.
// Reset (synchronous, active low) empties the queue and output register and
// returns to waiting for a frame start.
`default_nettype none
module char_stuffing_framer_top
    import csf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_word     o_data
);

    logic q_full, q_push, q_pop, q_valid;
    t_cmd push_cmd, head_cmd;

    csf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    csf_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    csf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking testbench for char_stuffing_framer_top (stx/etx framing, token doubling).
// Predicts framed words per input word; checks each output word in order under idle and stalls.
// Depends on csf_pkg and the char_stuffing_framer_top RTL.
`default_nettype none
module tb;
    import csf_pkg::*;

    localparam int STALL_LEN = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_data;

    char_stuffing_framer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (o_ready),
        .i_data  (in_word),
        .o_valid (o_valid),
        .i_ready (out_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  held [2];
    int unsigned held_cnt = 0;
    bit          framing = 1'b0;
    t_out_word   framed_q[$];
    logic [7:0]  run_bytes [12];
    int          run_n;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_ask = 0;
    int stall_seen = 0;
    int stall_left = 0;

    int fail_count = 0;
    int words_in = 0;
    int words_out = 0;
    int frames_closed = 0;

    function automatic bit is_token(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
        return (a == CH_D && b == CH_L && c == CH_E) ||
               (a == CH_S && b == CH_T && c == CH_X) ||
               (a == CH_E && b == CH_T && c == CH_X);
    endfunction

    task automatic note_byte(input logic [7:0] b);
        run_bytes[run_n] = b;
        run_n++;
    endtask

    task automatic predict_framing(input t_in_word w);
        logic [7:0]  win [3];
        int unsigned cnt;
        t_out_word   ow;
        run_n = 0;
        cnt = held_cnt;
        win[0] = held[0];
        win[1] = held[1];
        win[2] = 8'h00;
        if (!framing) begin
            note_byte(CH_S);
            note_byte(CH_T);
            note_byte(CH_X);
            framing = 1'b1;
            cnt = 0;
        end
        win[cnt] = w.data_byte;
        cnt++;
        if (cnt == 3) begin
            if (is_token(win[0], win[1], win[2])) begin
                note_byte(win[0]);
                note_byte(win[1]);
                note_byte(win[2]);
            end
            note_byte(win[0]);
            win[0] = win[1];
            win[1] = win[2];
            cnt = 2;
        end
        if (w.frame_end) begin
            for (int i = 0; i < int'(cnt); i++)
                note_byte(win[i]);
            note_byte(CH_E);
            note_byte(CH_T);
            note_byte(CH_X);
            cnt = 0;
            framing = 1'b0;
        end
        held[0] = win[0];
        held[1] = win[1];
        held_cnt = cnt;
        for (int i = 0; i < run_n; i++) begin
            ow.out_byte   = run_bytes[i];
            ow.run_last   = (i == run_n - 1);
            ow.frame_done = w.frame_end && (i == run_n - 1);
            framed_q.push_back(ow);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input bit last);
        t_in_word w;
        w.data_byte = b;
        w.frame_end = last;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_framing(w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        words_in++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (framed_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_string(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], close && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] alpha [6];
        alpha = '{CH_S, CH_T, CH_X, CH_D, CH_L, CH_E};
        if ($urandom_range(9) < 5)
            return alpha[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_frame();
        int          len;
        int          pos;
        logic [7:0]  tok [3];
        bit          close;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
        close = ($urandom_range(9) != 0);
        pos = 0;
        while (pos < len) begin
            if (len - pos >= 3 && $urandom_range(3) == 0) begin
                case ($urandom_range(2))
                    0: tok = '{CH_D, CH_L, CH_E};
                    1: tok = '{CH_S, CH_T, CH_X};
                    default: tok = '{CH_E, CH_T, CH_X};
                endcase
                for (int k = 0; k < 3; k++)
                    send_word(tok[k], close && (pos + k == len - 1));
                pos += 3;
            end else begin
                send_word(pick_byte(), close && (pos == len - 1));
                pos++;
            end
        end
    endtask

    task automatic test_directed_cases();
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_string("dletx", 1'b0);
        send_word(8'hFF, 1'b1);
        send_string("stx", 1'b1);
        send_string("et", 1'b1);
        send_string("etxdle", 1'b1);
        send_string("dl", 1'b0);
        send_word(8'h80, 1'b1);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_frames(input int n, input int src_pct, input int snk_pct);
        int start;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start = words_in;
        while (words_in - start < n)
            send_random_frame();
        send_word(pick_byte(), 1'b1);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_output_stall();
        src_idle_pct = 0;
        snk_idle_pct = 20;
        stall_ask <= stall_ask + 1;
        for (int i = 0; i < 20; i++)
            send_word(pick_byte(), (i % 7) == 6);
        // hold input until the output side has caught up
        stop_sending();
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_word(pick_byte(), i == 19);
        stop_sending();
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (stall_ask != stall_seen) begin
            stall_seen <= stall_ask;
            stall_left <= STALL_LEN;
            out_ready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && out_ready) begin
            words_out++;
            if (o_data.frame_done)
                frames_closed++;
            if (framed_q.size() == 0) begin
                $error("unexpected output word %h", o_data);
                fail_count++;
            end else begin
                exp_w = framed_q.pop_front();
                if (o_data.out_byte !== exp_w.out_byte) begin
                    $error("out_byte: expected %h, got %h", exp_w.out_byte, o_data.out_byte);
                    fail_count++;
                end
                if (o_data.run_last !== exp_w.run_last) begin
                    $error("run_last: expected %b, got %b", exp_w.run_last, o_data.run_last);
                    fail_count++;
                end
                if (o_data.frame_done !== exp_w.frame_done) begin
                    $error("frame_done: expected %b, got %b",
                           exp_w.frame_done, o_data.frame_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("char_stuffing_framer_top verification failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_frames(130, 36, 86);
        test_random_frames(130, 86, 36);
        test_random_frames(130, 0, 0);
        test_output_stall();
        repeat (20) @(posedge i_clk);
        if (framed_q.size() != 0) begin
            $error("%0d expected output words never arrived", framed_q.size());
            fail_count++;
        end
        $display("Sent %0d payload bytes; checked %0d framed bytes over %0d closed frames,",
                 words_in, words_out, frames_closed);
        $display("with idle on either side, a long output stall and a drain pause.");
        if (fail_count == 0)
            $display("char_stuffing_framer_top verification clean");
        else
            $display("char_stuffing_framer_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire
